[src/sqe_pkg.sv]
// ----------------------------------------------------------------------------
// sqe_pkg
// Types, character codes and helper functions shared by the string quote and
// escape unit.
// ----------------------------------------------------------------------------
package sqe_pkg;

   localparam int unsigned MaxOut = 8;
   localparam int unsigned EscMax = 6;

   localparam logic [7:0] CHR_QUOTE  = 8'd34;
   localparam logic [7:0] CHR_BSLASH = 8'd92;
   localparam logic [7:0] CHR_SPACE  = 8'd32;
   localparam logic [7:0] CHR_DEL    = 8'd127;
   localparam logic [7:0] CHR_ZERO   = 8'd48;
   localparam logic [7:0] CHR_U      = 8'd117;
   localparam logic [7:0] CHR_T      = 8'd116;
   localparam logic [7:0] CHR_B      = 8'd98;
   localparam logic [7:0] CHR_F      = 8'd102;
   localparam logic [7:0] CHR_N      = 8'd110;
   localparam logic [7:0] CHR_R      = 8'd114;

   localparam logic [7:0] CTL_BS  = 8'd8;
   localparam logic [7:0] CTL_TAB = 8'd9;
   localparam logic [7:0] CTL_LF  = 8'd10;
   localparam logic [7:0] CTL_FF  = 8'd12;
   localparam logic [7:0] CTL_CR  = 8'd13;

   typedef enum logic [1:0] {
      ESC_PASS,
      ESC_PAIR,
      ESC_HEX
   } esc_kind_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       first;
      logic       last;
   } req_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
   } rsp_item_type;

   // Item after classification.
   typedef struct packed {
      logic [7:0]   data_byte;
      logic         has_byte;
      logic         first;
      logic         last;
      esc_kind_type kind;
      logic [7:0]   letter;
   } cls_item_type;

   // Fully expanded item: up to eight output bytes, byte 0 goes out first.
   typedef struct packed {
      logic [MaxOut-1:0][7:0] bytes;
      logic [3:0]             count;
   } run_item_type;

   // Uppercase hex digit of a nibble.
   function automatic logic [7:0] hex_digit(input logic [3:0] nib);
      logic [7:0] d;
      d = CHR_ZERO + {4'd0, nib};
      if (nib > 4'd9) begin
         d = d + 8'd7;
      end
      return d;
   endfunction

endpackage

[src/sqe_classify.sv]
// ----------------------------------------------------------------------------
// sqe_classify
// First pipeline stage: decides how the byte of an item is escaped and picks
// the letter of the short two-byte escapes.
// ----------------------------------------------------------------------------
module sqe_classify (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_stall,
   input  sqe_pkg::req_item_type in_item,
   output logic                 out_valid,
   input  logic                 out_stall,
   output sqe_pkg::cls_item_type out_item
);
   import sqe_pkg::*;

   logic         valid_ff;
   cls_item_type item_ff;
   cls_item_type item_in;
   logic         advance;

   assign advance = !valid_ff || !out_stall;
   assign in_stall = !advance;

   always_comb begin
      item_in.data_byte = in_item.data_byte;
      item_in.has_byte  = in_item.has_byte;
      item_in.first     = in_item.first;
      item_in.last      = in_item.last;
      item_in.letter    = in_item.data_byte;
      item_in.kind      = ESC_PAIR;
      case (in_item.data_byte)
         CTL_TAB:    item_in.letter = CHR_T;
         CTL_BS:     item_in.letter = CHR_B;
         CTL_FF:     item_in.letter = CHR_F;
         CTL_LF:     item_in.letter = CHR_N;
         CTL_CR:     item_in.letter = CHR_R;
         CHR_QUOTE:  item_in.letter = CHR_QUOTE;
         CHR_BSLASH: item_in.letter = CHR_BSLASH;
         default: begin
            if (in_item.data_byte >= CHR_SPACE && in_item.data_byte < CHR_DEL) begin
               item_in.kind = ESC_PASS;
            end else begin
               item_in.kind = ESC_HEX;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

[src/sqe_expand.sv]
// ----------------------------------------------------------------------------
// sqe_expand
// Second pipeline stage: lays out the quotes and the escaped byte of an item
// as a run of up to eight bytes. Items that make no bytes are dropped here.
// ----------------------------------------------------------------------------
module sqe_expand (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_stall,
   input  sqe_pkg::cls_item_type in_item,
   output logic                 out_valid,
   input  logic                 out_stall,
   output sqe_pkg::run_item_type out_item
);
   import sqe_pkg::*;

   logic                 valid_ff;
   run_item_type         run_ff;
   run_item_type         run_in;
   logic                 advance;
   logic [MaxOut-1:0][7:0] esc;
   logic [2:0]           esc_len;
   logic [3:0]           pos;

   assign advance = !valid_ff || !out_stall;
   assign in_stall = !advance;

   always_comb begin
      esc     = '0;
      esc_len = 3'd1;
      case (in_item.kind)
         ESC_PASS: begin
            esc[0]  = in_item.data_byte;
            esc_len = 3'd1;
         end
         ESC_PAIR: begin
            esc[0]  = CHR_BSLASH;
            esc[1]  = in_item.letter;
            esc_len = 3'd2;
         end
         ESC_HEX: begin
            esc[0]  = CHR_BSLASH;
            esc[1]  = CHR_U;
            esc[2]  = CHR_ZERO;
            esc[3]  = CHR_ZERO;
            esc[4]  = hex_digit(in_item.data_byte[7:4]);
            esc[5]  = hex_digit(in_item.data_byte[3:0]);
            esc_len = 3'd6;
         end
         default: begin
            esc[0]  = in_item.data_byte;
            esc_len = 3'd1;
         end
      endcase
      if (!in_item.has_byte) begin
         esc_len = 3'd0;
      end
   end

   always_comb begin
      run_in.count = {3'd0, in_item.first} + {1'b0, esc_len} + {3'd0, in_item.last};
      run_in.bytes = '0;
      pos = '0;
      for (int k = 0; k < MaxOut; k++) begin
         // Position of this output byte within the escaped byte.
         pos = 4'(k) - {3'd0, in_item.first};
         if (in_item.first && k == 0) begin
            run_in.bytes[k] = CHR_QUOTE;
         end else if (pos < {1'b0, esc_len}) begin
            run_in.bytes[k] = esc[pos[2:0]];
         end else if (in_item.last && 4'(k) == run_in.count - 4'd1) begin
            run_in.bytes[k] = CHR_QUOTE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid && (run_in.count != 4'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         run_ff <= run_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = run_ff;

endmodule

[src/sqe_serialize.sv]
// ----------------------------------------------------------------------------
// sqe_serialize
// Output stage: holds one run of bytes and shifts it out one byte per cycle
// while the receiver does not stall, marking the final byte of the run.
// ----------------------------------------------------------------------------
module sqe_serialize (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_stall,
   input  sqe_pkg::run_item_type in_item,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output sqe_pkg::rsp_item_type rsp_payload
);
   import sqe_pkg::*;

   logic                   valid_ff;
   logic                   valid_in;
   logic [MaxOut-1:0][7:0] bytes_ff;
   logic [MaxOut-1:0][7:0] bytes_in;
   logic [3:0]             cnt_ff;
   logic [3:0]             cnt_in;
   logic                   take;
   logic                   load;

   assign take = valid_ff && !rsp_stall;
   // A new run loads once the current one has sent its final byte.
   assign load = !valid_ff || (take && cnt_ff == 4'd1);
   assign in_stall = !load;

   always_comb begin
      valid_in = valid_ff;
      bytes_in = bytes_ff;
      cnt_in   = cnt_ff;
      if (load) begin
         valid_in = in_valid;
         bytes_in = in_item.bytes;
         cnt_in   = in_item.count;
      end else if (take) begin
         bytes_in = {8'd0, bytes_ff[MaxOut-1:1]};
         cnt_in   = cnt_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
   end

   assign rsp_valid               = valid_ff;
   assign rsp_payload.out_byte    = bytes_ff[0];
   assign rsp_payload.last_of_run = (cnt_ff == 4'd1);

`ifndef SYNTH
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (cnt_ff != 4'd0 && cnt_ff <= 4'(MaxOut)))
      else $error("held run has an impossible byte count");

   a_count_steps: assert property (@(posedge clock) disable iff (reset)
      (take && cnt_ff > 4'd1) |=> (valid_ff && cnt_ff == $past(cnt_ff) - 4'd1))
      else $error("run count did not step down after a byte was taken");

   a_load_takes: assert property (@(posedge clock) disable iff (reset)
      (load && in_valid) |=> (valid_ff && cnt_ff == $past(in_item.count)))
      else $error("accepted run was not loaded");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && rsp_stall) |=> (valid_ff && $stable(cnt_ff)))
      else $error("run count moved while the output was stalled");
`endif

endmodule

[src/string_quote_escape_unit.sv]
// An item's first result byte reaches the output after passing the classify,
// expand and serializer registers.
// Throughput: one result byte per cycle while the receiver does not stall; the single
// output byte serializer loads a new run only once the current one has sent its
// final byte, stalling the input meanwhile. Items that make no result byte are dropped.
// Reset is synchronous and active high, and empties all three stages.
// ----------------------------------------------------------------------------
// string_quote_escape_unit
// Turns a stream of string bytes into quoted, escaped text: classify stage,
// expand stage and output serializer.
// ----------------------------------------------------------------------------
module string_quote_escape_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  sqe_pkg::req_item_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output sqe_pkg::rsp_item_type rsp_payload
);
   import sqe_pkg::*;

   logic         cls_valid;
   logic         cls_stall;
   cls_item_type cls_item;
   logic         run_valid;
   logic         run_stall;
   run_item_type run_item;

   sqe_classify u_classify (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_item   (req_payload),
      .out_valid (cls_valid),
      .out_stall (cls_stall),
      .out_item  (cls_item)
   );

   sqe_expand u_expand (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cls_valid),
      .in_stall  (cls_stall),
      .in_item   (cls_item),
      .out_valid (run_valid),
      .out_stall (run_stall),
      .out_item  (run_item)
   );

   sqe_serialize u_serialize (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (run_valid),
      .in_stall    (run_stall),
      .in_item     (run_item),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

[tb/string_quote_escape_unit_tb.sv]
// ----------------------------------------------------------------------------
// string_quote_escape_unit_tb
// Drives strings through the quote and escape unit and checks every output
// byte against a predicted copy of the quoted, escaped text, across phases of
// sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module string_quote_escape_unit_tb;
   import sqe_pkg::*;

   localparam int unsigned HangLimit = 1000;
   localparam int unsigned TailCycles = 16;
   localparam logic [7:0] CHR_UPPER_A = "A";

   typedef struct {
      req_item_type item;
      int unsigned  idle_pct;
      int unsigned  stall_pct;
      bit           wait_drain;
   } queued_req_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_item_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_item_type rsp_payload;

   queued_req_type pending_reqs[$];
   rsp_item_type escaped_text_q[$];

   int unsigned recv_stall_pct = 0;
   int unsigned accepted_items = 0;
   int unsigned checked_bytes = 0;
   int unsigned hex_escapes = 0;
   int unsigned pair_escapes = 0;
   int unsigned mismatch_count = 0;
   int unsigned hang_cycles = 0;

   string_quote_escape_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [7:0] nibble_char(input logic [3:0] n);
      return (n < 4'd10) ? CHR_ZERO + {4'd0, n} : CHR_UPPER_A + {4'd0, n} - 8'd10;
   endfunction

   // Appends the bytes that one accepted item should produce.
   function automatic void queue_escaped_bytes(input req_item_type it);
      logic [7:0] seq[$];
      logic [7:0] c;
      c = it.data_byte;
      if (it.first) seq.push_back(CHR_QUOTE);
      if (it.has_byte) begin
         if (c >= CHR_SPACE && c < CHR_DEL && c != CHR_BSLASH && c != CHR_QUOTE) begin
            seq.push_back(c);
         end else begin
            seq.push_back(CHR_BSLASH);
            pair_escapes++;
            case (c)
               CTL_TAB:    seq.push_back(CHR_T);
               CTL_BS:     seq.push_back(CHR_B);
               CTL_FF:     seq.push_back(CHR_F);
               CTL_LF:     seq.push_back(CHR_N);
               CTL_CR:     seq.push_back(CHR_R);
               CHR_QUOTE:  seq.push_back(CHR_QUOTE);
               CHR_BSLASH: seq.push_back(CHR_BSLASH);
               default: begin
                  // Bytes only reach 0xFF, so the two upper digits are always zero.
                  pair_escapes--;
                  hex_escapes++;
                  seq.push_back(CHR_U);
                  seq.push_back(CHR_ZERO);
                  seq.push_back(CHR_ZERO);
                  seq.push_back(nibble_char(c[7:4]));
                  seq.push_back(nibble_char(c[3:0]));
               end
            endcase
         end
      end
      if (it.last) seq.push_back(CHR_QUOTE);
      foreach (seq[k]) begin
         escaped_text_q.push_back(rsp_item_type'{out_byte: seq[k],
                                                 last_of_run: (k == seq.size() - 1)});
      end
   endfunction

   function automatic logic [7:0] random_text_byte();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return 8'($urandom_range(32, 126));
         5: begin
            case ($urandom_range(0, 6))
               0: return CTL_BS;
               1: return CTL_TAB;
               2: return CTL_LF;
               3: return CTL_FF;
               4: return CTL_CR;
               5: return CHR_QUOTE;
               default: return CHR_BSLASH;
            endcase
         end
         6: return 8'($urandom_range(0, 31));
         7, 8: return 8'($urandom_range(127, 255));
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic push_req(input logic [7:0] b, input logic has, input logic f,
                           input logic l, input int unsigned idle,
                           input int unsigned stall, input bit drain);
      queued_req_type q;
      q.item = req_item_type'{data_byte: b, has_byte: has, first: f, last: l};
      q.idle_pct = idle;
      q.stall_pct = stall;
      q.wait_drain = drain;
      pending_reqs.push_back(q);
   endtask

   // Mostly well-formed strings of random length, with some loose items mixed in.
   // The first item of each phase waits until all earlier output has drained.
   task automatic add_random_phase(input int unsigned idle, input int unsigned stall,
                                   input int unsigned budget);
      int unsigned made;
      int unsigned len;
      bit drain;
      logic has;
      logic f;
      logic l;
      made = 0;
      drain = 1'b1;
      while (made < budget) begin
         if ($urandom_range(0, 99) < 15) begin
            has = 1'($urandom);
            f = 1'($urandom);
            l = 1'($urandom);
            push_req(8'($urandom), has, f, l, idle, stall, drain);
            drain = 1'b0;
            if (has || f || l) made++;
         end else begin
            len = $urandom_range(0, 6);
            if (len == 0) begin
               push_req(8'($urandom), 1'b0, 1'b1, 1'b1, idle, stall, drain);
               drain = 1'b0;
               made++;
            end else begin
               for (int unsigned k = 0; k < len; k++) begin
                  push_req(random_text_byte(), 1'b1, k == 0, k == len - 1,
                           idle, stall, drain);
                  drain = 1'b0;
                  made++;
               end
            end
         end
      end
   endtask

   // Driver: predicts on acceptance, then offers the next item or idles.
   always @(posedge clock) begin
      queued_req_type nxt;
      logic offer;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         offer = req_valid;
         if (req_valid && !req_stall) begin
            queue_escaped_bytes(req_payload);
            accepted_items++;
            offer = 1'b0;
         end
         if (!offer && pending_reqs.size() != 0) begin
            nxt = pending_reqs[0];
            if (!(nxt.wait_drain && escaped_text_q.size() != 0)
                && $urandom_range(0, 99) >= nxt.idle_pct) begin
               void'(pending_reqs.pop_front());
               req_payload <= nxt.item;
               recv_stall_pct <= nxt.stall_pct;
               offer = 1'b1;
            end
         end
         req_valid <= offer;
      end
   end

   // Monitor: checks each accepted output byte against the oldest prediction.
   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            checked_bytes++;
            if (escaped_text_q.size() == 0) begin
               if (mismatch_count < 10)
                  $display("unexpected output byte %02h last_of_run %0b",
                           rsp_payload.out_byte, rsp_payload.last_of_run);
               mismatch_count++;
            end else begin
               want = escaped_text_q.pop_front();
               if (rsp_payload.out_byte !== want.out_byte
                   || rsp_payload.last_of_run !== want.last_of_run) begin
                  if (mismatch_count < 10)
                     $display("output byte %0d: expected %02h/%0b, got %02h/%0b",
                              checked_bytes, want.out_byte, want.last_of_run,
                              rsp_payload.out_byte, rsp_payload.last_of_run);
                  mismatch_count++;
               end
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         hang_cycles <= 0;
      end else if (hang_cycles + 1 >= HangLimit) begin
         $display("no handshake for %0d cycles, %0d bytes still expected",
                  HangLimit, escaped_text_q.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         hang_cycles <= hang_cycles + 1;
      end
   end

   initial begin
      // Directed items: empty string, dropped item, range edges, every
      // two-character escape, hex escapes and flags out of order.
      push_req(8'h00, 1'b0, 1'b1, 1'b1, 0, 0, 1'b0);
      push_req(8'hA5, 1'b0, 1'b0, 1'b0, 0, 0, 1'b0);
      push_req(8'h00, 1'b1, 1'b1, 1'b0, 0, 0, 1'b0);
      push_req(8'hFF, 1'b1, 1'b0, 1'b0, 0, 0, 1'b0);
      push_req(CHR_SPACE, 1'b1, 1'b0, 1'b0, 0, 0, 1'b0);
      push_req(8'h7E, 1'b1, 1'b0, 1'b0, 0, 0, 1'b0);
      push_req(CHR_DEL, 1'b1, 1'b0, 1'b0, 0, 0, 1'b0);
      push_req(8'h1F, 1'b1, 1'b0, 1'b1, 0, 0, 1'b0);
      push_req(CTL_BS, 1'b1, 1'b1, 1'b1, 0, 0, 1'b0);
      push_req(CTL_TAB, 1'b1, 1'b0, 1'b0, 0, 0, 1'b0);
      push_req(CTL_LF, 1'b1, 1'b0, 1'b0, 0, 0, 1'b0);
      push_req(CTL_FF, 1'b1, 1'b0, 1'b0, 0, 0, 1'b0);
      push_req(CTL_CR, 1'b1, 1'b0, 1'b0, 0, 0, 1'b0);
      push_req(CHR_QUOTE, 1'b1, 1'b0, 1'b0, 0, 0, 1'b0);
      push_req(CHR_BSLASH, 1'b1, 1'b0, 1'b1, 0, 0, 1'b0);
      push_req(8'h41, 1'b1, 1'b0, 1'b1, 0, 0, 1'b0);
      push_req(8'h00, 1'b0, 1'b1, 1'b0, 0, 0, 1'b0);
      push_req(8'hFF, 1'b0, 1'b1, 1'b0, 0, 0, 1'b0);
      push_req(8'h80, 1'b1, 1'b1, 1'b1, 0, 0, 1'b0);
      push_req(8'hFF, 1'b0, 1'b0, 1'b1, 0, 0, 1'b0);
      push_req(CHR_BSLASH, 1'b1, 1'b1, 1'b1, 0, 0, 1'b0);
      push_req(8'h0B, 1'b1, 1'b0, 1'b1, 0, 0, 1'b0);

      add_random_phase(0, 0, 60);
      add_random_phase(85, 0, 60);
      add_random_phase(0, 85, 60);
      add_random_phase(12, 12, 60);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_valid || escaped_text_q.size() != 0);
      repeat (TailCycles) @(posedge clock);

      $display("%0d items in, %0d output bytes checked (%0d two-character and %0d hex escapes)",
               accepted_items, checked_bytes, pair_escapes, hex_escapes);
      $display("phases: no idling, idle sender, stalling receiver, light mixed idling");
      if (mismatch_count == 0 && escaped_text_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches, %0d bytes never seen", mismatch_count,
                  escaped_text_q.size());
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
